@@ rtl/bfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types and constants of the 2x2 box filter downsampler.
// ----------------------------------------------------------------------------
package bfd_pkg;

    localparam int CFG_W          = 11;   // width of the size registers
    localparam int CFG_IDX_W      = 2;    // register index of the config port
    localparam int BYTE_W         = 8;    // one channel of a pixel
    localparam int PAIR_W         = 9;    // sum of two channel bytes
    localparam int NUM_CHAN_PORTS = 4;    // channel ports on the pixel channels

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_CHANNELS  = 4;

    localparam logic [CFG_W-1:0] RESET_IMAGE_WIDTH  = CFG_W'(128);
    localparam logic [CFG_W-1:0] RESET_IMAGE_HEIGHT = CFG_W'(128);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [PAIR_W-1:0] t_pair;

    // per accepted item: what the position in the frame asks of the datapath
    typedef struct packed {
        logic hold;     // even column: keep pixel as left half of the pair
        logic line_wr;  // odd column, even row: store pair sum in the line
        logic emit;     // odd column, odd row: read line and make an output
        logic last;     // this output closes the frame
    } t_step_ctl;

endpackage

@@ rtl/bfd_line_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_line_mem
// Line store of pair sums: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bfd_line_mem #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9,
    parameter int DATA_W = 36
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bfd_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_lane
// One color channel: horizontal pair sum, then vertical combine and rounding.
// ----------------------------------------------------------------------------
module bfd_lane (
    input  logic          i_clk,
    input  bfd_pkg::t_byte i_pix,
    input  logic          i_hold_en,
    input  logic          i_s1_en,
    input  logic          i_out_en,
    input  bfd_pkg::t_pair i_line_sum,
    output bfd_pkg::t_pair o_pair,
    output bfd_pkg::t_byte o_mean
);
    import bfd_pkg::*;

    localparam int SUM_W = PAIR_W + 1;

    t_byte             r_left;
    t_pair             r_pair;
    t_byte             r_mean;
    logic [SUM_W-1:0]  quad_sum;

    assign o_pair   = PAIR_W'(r_left) + PAIR_W'(i_pix);
    // stored pair from the even row, new pair, and the rounding term
    assign quad_sum = SUM_W'(i_line_sum) + SUM_W'(r_pair) + SUM_W'(2);

    always_ff @(posedge i_clk) begin
        if (i_hold_en) begin
            r_left <= i_pix;
        end
        if (i_s1_en) begin
            r_pair <= o_pair;
        end
        if (i_out_en) begin
            r_mean <= quad_sum[SUM_W-1:2];
        end
    end

    assign o_mean = r_mean;

endmodule

@@ rtl/bfd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_ctrl
// Size registers, column and row counters, and per-item datapath control.
// ----------------------------------------------------------------------------
module bfd_ctrl #(
    parameter int MAX_WIDTH = bfd_pkg::DEF_MAX_WIDTH,
    parameter int LINE_AW   = 9
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bfd_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_step,
    output bfd_pkg::t_step_ctl             o_ctl,
    output logic [LINE_AW-1:0]             o_slot
);
    import bfd_pkg::*;

    localparam int MaxWBits = $clog2(MAX_WIDTH + 1);
    localparam int CmpW     = (MaxWBits > CFG_W) ? MaxWBits : CFG_W;
    localparam int PosW     = CFG_W + 1;

    logic [CFG_W-1:0] r_width, n_width;
    logic [CFG_W-1:0] r_height, n_height;
    logic [CFG_W-1:0] r_col, n_col;
    logic [CFG_W-1:0] r_row, n_row;

    logic [CFG_W-1:0] w_eff;
    logic [CFG_W-1:0] even_w;
    logic [CFG_W-1:0] even_h;
    logic [PosW-1:0]  col_inc;
    logic [PosW-1:0]  row_inc;
    logic             in_frame;
    logic             col_wrap;
    logic             row_wrap;

    // widths beyond the line store are clipped
    assign w_eff  = (CmpW'(r_width) > CmpW'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : r_width;
    assign even_w = {w_eff[CFG_W-1:1], 1'b0};
    assign even_h = {r_height[CFG_W-1:1], 1'b0};

    assign col_inc  = PosW'(r_col) + PosW'(1);
    assign row_inc  = PosW'(r_row) + PosW'(1);
    assign col_wrap = col_inc >= PosW'(w_eff);
    assign row_wrap = row_inc >= PosW'(r_height);

    // odd trailing column or row falls outside and is dropped
    assign in_frame = (w_eff > CFG_W'(1)) && (r_height > CFG_W'(1))
                   && (r_col < even_w) && (r_row < even_h);

    always_comb begin
        o_ctl.hold    = i_step && in_frame && !r_col[0];
        o_ctl.line_wr = i_step && in_frame && r_col[0] && !r_row[0];
        o_ctl.emit    = i_step && in_frame && r_col[0] && r_row[0];
        o_ctl.last    = (row_inc == PosW'(even_h)) && (col_inc == PosW'(even_w));
    end

    assign o_slot = LINE_AW'(r_col >> 1);

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_row    = r_row;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH: begin
                    n_width = i_cfg_data;
                    n_col   = '0;
                    n_row   = '0;
                end
                REG_IMAGE_HEIGHT: begin
                    n_height = i_cfg_data;
                    n_col    = '0;
                    n_row    = '0;
                end
                default: begin
                end
            endcase
        end else if (i_step) begin
            if (col_wrap) begin
                n_col = '0;
                n_row = row_wrap ? '0 : row_inc[CFG_W-1:0];
            end else begin
                n_col = col_inc[CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_IMAGE_WIDTH;
            r_height <= RESET_IMAGE_HEIGHT;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

`ifndef ASSERT_OFF
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_index == REG_IMAGE_WIDTH || i_cfg_index == REG_IMAGE_HEIGHT)
        |=> (r_col == '0) && (r_row == '0))
        else $error("frame position not restarted after size write");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col < w_eff) || (r_col == '0))
        else $error("column counter beyond image width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row < r_height) || (r_row == '0))
        else $error("row counter beyond image height");
`endif

endmodule

@@ rtl/box_filter_downsample_2x2_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_downsample_2x2_unit
// Halves an RGBA image in both directions with a rounded 2x2 box filter.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on the in channel (valid/ready), one item per
//   pixel. Width and height are set through the write port (index 0 width,
//   index 1 height, reset 128 x 128); a write restarts the frame position and
//   must be done only while the unit is idle, which the unit does not enforce.
//   An output item leaves for each input pixel at an odd row and odd column
//   inside the even-sized part of the frame; o_out_last marks the final one.
//   After its pixel is accepted, an output passes the pair stage with the line
//   store read, then the output register.
//   Throughput: one pixel per clock while the receiver does not stall, set by
//   the channel lanes and the line store with one write and one read port.
//   When the receiver stalls, the output register and the pair stage hold and
//   in ready drops once both are full; ready returns with i_out_ready.
//   Reset clears the frame position and the pipeline valid bits; the line
//   store is not cleared, every odd row reads what its even row wrote.
// ----------------------------------------------------------------------------
module box_filter_downsample_2x2_unit #(
    parameter int MAX_WIDTH = bfd_pkg::DEF_MAX_WIDTH,
    parameter int CHANNELS  = bfd_pkg::DEF_CHANNELS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bfd_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bfd_pkg::BYTE_W-1:0]    i_in_chan0,
    input  logic [bfd_pkg::BYTE_W-1:0]    i_in_chan1,
    input  logic [bfd_pkg::BYTE_W-1:0]    i_in_chan2,
    input  logic [bfd_pkg::BYTE_W-1:0]    i_in_chan3,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bfd_pkg::BYTE_W-1:0]    o_out_chan0,
    output logic [bfd_pkg::BYTE_W-1:0]    o_out_chan1,
    output logic [bfd_pkg::BYTE_W-1:0]    o_out_chan2,
    output logic [bfd_pkg::BYTE_W-1:0]    o_out_chan3,
    output logic                          o_out_last
);
    import bfd_pkg::*;

    localparam int LineDepth = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
    localparam int LineAw    = (LineDepth > 1) ? $clog2(LineDepth) : 1;
    localparam int LineW     = CHANNELS * PAIR_W;

    t_step_ctl          ctl;
    logic [LineAw-1:0]  slot;
    logic               in_accept;
    logic               out_adv;
    logic               s1_adv;
    logic               out_en;

    logic               r_s1_valid;
    logic               r_s1_last;
    logic               r_out_valid;
    logic               r_out_last;

    t_byte              pix  [NUM_CHAN_PORTS];
    t_byte              mean [NUM_CHAN_PORTS];
    logic [LineW-1:0]   line_wdata;
    logic [LineW-1:0]   line_rdata;

    assign out_adv    = !r_out_valid || i_out_ready;
    assign s1_adv     = !r_s1_valid || out_adv;
    assign o_in_ready = s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_en     = r_s1_valid && out_adv;

    assign pix[0] = i_in_chan0;
    assign pix[1] = i_in_chan1;
    assign pix[2] = i_in_chan2;
    assign pix[3] = i_in_chan3;

    bfd_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .LINE_AW   (LineAw)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (in_accept),
        .o_ctl       (ctl),
        .o_slot      (slot)
    );

    bfd_line_mem #(
        .DEPTH  (LineDepth),
        .ADDR_W (LineAw),
        .DATA_W (LineW)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ctl.line_wr),
        .i_waddr (slot),
        .i_wdata (line_wdata),
        .i_re    (ctl.emit),
        .i_raddr (slot),
        .o_rdata (line_rdata)
    );

    // one lane per channel in use; channels beyond that read as zero
    for (genvar c = 0; c < NUM_CHAN_PORTS; c++) begin : g_chan
        if (c < CHANNELS) begin : g_lane
            bfd_lane u_lane (
                .i_clk      (i_clk),
                .i_pix      (pix[c]),
                .i_hold_en  (ctl.hold),
                .i_s1_en    (ctl.emit),
                .i_out_en   (out_en),
                .i_line_sum (line_rdata[c*PAIR_W +: PAIR_W]),
                .o_pair     (line_wdata[c*PAIR_W +: PAIR_W]),
                .o_mean     (mean[c])
            );
        end else begin : g_unused
            assign mean[c] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= ctl.emit;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.emit) begin
            r_s1_last <= ctl.last;
        end
        if (out_en) begin
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_last  = r_out_last;
    assign o_out_chan0 = mean[0];
    assign o_out_chan1 = mean[1];
    assign o_out_chan2 = mean[2];
    assign o_out_chan3 = mean[3];

`ifndef ASSERT_OFF
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !i_out_ready |=> r_s1_valid)
        else $error("pair stage lost its item while output stalled");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_s1_valid && r_out_valid)
        else $error("input stalled with room in the pipeline");

    a_emit_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.emit |=> r_s1_valid)
        else $error("output item did not enter the pair stage");
`endif

endmodule
